>>> src/tbsv_pkg.sv
// Types, constants and helper functions shared by the tile body validator.
// No dependencies; compile this file first.
package tbsv_pkg;

   typedef struct packed {
      logic [2:0]  product_class;
      logic [7:0]  max_palette_entries;
      logic [7:0]  max_active_layers;
      logic [16:0] sample_count;
   } cfg_type;

   localparam logic [1:0] CSR_PRODUCT_CLASS = 2'd0;
   localparam logic [1:0] CSR_MAX_PALETTE   = 2'd1;
   localparam logic [1:0] CSR_MAX_LAYERS    = 2'd2;
   localparam logic [1:0] CSR_SAMPLE_COUNT  = 2'd3;

   localparam logic [2:0] CLS_META      = 3'd0;
   localparam logic [2:0] CLS_HEIGHT    = 3'd1;
   localparam logic [2:0] CLS_COVERAGE  = 3'd2;
   localparam logic [2:0] CLS_COLLISION = 3'd3;
   localparam logic [2:0] CLS_QUERY     = 3'd4;

   localparam logic [3:0] ERR_OK          = 4'd0;
   localparam logic [3:0] ERR_SIZE        = 4'd1;
   localparam logic [3:0] ERR_GRID        = 4'd2;
   localparam logic [3:0] ERR_COV_HEADER  = 4'd3;
   localparam logic [3:0] ERR_PAL_TRUNC   = 4'd4;
   localparam logic [3:0] ERR_COUNT       = 4'd5;
   localparam logic [3:0] ERR_SMP_TRUNC   = 4'd6;
   localparam logic [3:0] ERR_SAMPLE      = 4'd7;
   localparam logic [3:0] ERR_WEIGHT_SUM  = 4'd8;
   localparam logic [3:0] ERR_TRAILING    = 4'd9;
   localparam logic [3:0] ERR_META_HEADER = 4'd10;
   localparam logic [3:0] ERR_DIRECTORY   = 4'd11;
   localparam logic [3:0] ERR_META_VALUES = 4'd12;

   localparam logic [3:0] PH_HEADER  = 4'd0;
   localparam logic [3:0] PH_PALETTE = 4'd1;
   localparam logic [3:0] PH_COUNT   = 4'd2;
   localparam logic [3:0] PH_INDEX   = 4'd3;
   localparam logic [3:0] PH_WEIGHT  = 4'd4;
   localparam logic [3:0] PH_TRAIL   = 4'd5;

   localparam logic [18:0] TOTAL_MAX      = 19'h7FFFF;
   localparam logic [18:0] HEIGHT_LEN     = 19'd132102;
   localparam logic [18:0] COLLISION_LEN  = 19'd33286;
   localparam logic [18:0] QUERY_LEN      = 19'd116491;
   localparam logic [18:0] META_LEN       = 19'd90;
   localparam logic [15:0] COV_GRID       = 16'd257;
   localparam logic [15:0] FINE_GRID      = 16'd257;
   localparam logic [15:0] COARSE_GRID    = 16'd129;
   localparam logic [7:0]  DIR_ENTRIES    = 8'd5;
   localparam logic [15:0] WEIGHT_TARGET  = 16'd255;

   function automatic logic [18:0] size_bound(input logic [2:0] cls);
      logic [18:0] r;
      case (cls)
         CLS_META:      r = 19'd16276;
         CLS_HEIGHT:    r = 19'd163732;
         CLS_COVERAGE:  r = 19'd327572;
         CLS_COLLISION: r = 19'd98196;
         CLS_QUERY:     r = 19'd163732;
         default:       r = 19'd0;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] dir_ceiling(input logic [2:0] k);
      logic [31:0] r;
      case (k)
         3'd0:    r = 32'd16384;
         3'd1:    r = 32'd163840;
         3'd2:    r = 32'd327680;
         3'd3:    r = 32'd98304;
         3'd4:    r = 32'd163840;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   function automatic logic is_finite(input logic [63:0] b);
      return b[62:52] != 11'h7FF;
   endfunction

   function automatic logic [63:0] order_key(input logic [63:0] b);
      return b[63] ? ~b : (b | 64'h8000_0000_0000_0000);
   endfunction

   function automatic logic dbl_greater(input logic [63:0] a, input logic [63:0] b);
      logic both_zero;
      both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
      return !both_zero && (order_key(a) > order_key(b));
   endfunction

endpackage

>>> src/tbsv_req_if.sv
// Input channel of the tile body validator: at most one body byte per transaction.
// Uses no package.
interface tbsv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       last;

   modport source (output valid, data_byte, byte_present, last, input ready);
   modport sink (input valid, data_byte, byte_present, last, output ready);
endinterface

>>> src/tbsv_rsp_if.sv
// Result channel of the tile body validator: one verdict per body.
// Uses no package.
interface tbsv_rsp_if;
   logic       valid;
   logic       ready;
   logic       valid_res;
   logic [3:0] error_code;

   modport source (output valid, valid_res, error_code, input ready);
   modport sink (input valid, valid_res, error_code, output ready);
endinterface

>>> src/tbsv_core.sv
// Parse state of the tile body validator and the verdict logic.
// Depends on tbsv_pkg.
module tbsv_core (
   input  logic             clock,
   input  logic             reset,
   input  tbsv_pkg::cfg_type cfg,
   input  logic             fire,
   input  logic [7:0]       data_byte,
   input  logic             byte_present,
   input  logic             last,
   output logic [3:0]       code
);

   logic [18:0] byte_total_ff, byte_total_in;
   logic [3:0]  phase_ff, phase_in;
   logic [63:0] shift_ff, shift_in;
   logic [3:0]  first_error_ff, first_error_in;
   logic [7:0]  palette_ff, palette_in;
   logic [16:0] samples_ff, samples_in;
   logic [7:0]  pairs_ff, pairs_in;
   logic [7:0]  prior_ff, prior_in;
   logic [15:0] weight_ff, weight_in;
   logic [31:0] hmin_ff, hmin_in;
   logic        fault_ff, fault_in;
   logic [63:0] lower_ff [3];
   logic        lower_we;
   logic [1:0]  lower_wa;

   always_comb begin
      logic [18:0]        pos;
      logic [2:0]         cls;
      logic [63:0]        ns;
      logic [3:0]         err;
      logic [2:0]         k;
      logic [4:0]         rel;
      logic [2:0]         dk;
      logic [4:0]         dj;
      logic [15:0]        w;
      logic [15:0]        h;
      logic               first;
      logic [15:0]        wsum;
      logic [7:0]         pleft;
      logic [16:0]        sdone;
      logic signed [31:0] mn;
      logic signed [31:0] mx;
      logic [15:0]        dim;
      pos = byte_total_ff;
      cls = cfg.product_class;
      ns = {data_byte, shift_ff[63:8]};
      err = first_error_ff;
      k = pos[5:3] - 3'd1;
      rel = 5'(pos - 19'd65);
      dk = (rel >= 5'd20) ? 3'd4 : (rel >= 5'd15) ? 3'd3 : (rel >= 5'd10) ? 3'd2 :
           (rel >= 5'd5) ? 3'd1 : 3'd0;
      dj = rel - 5'(dk) * 5'd5;
      w = ns[39:24];
      h = ns[55:40];
      first = shift_ff[8];
      wsum = weight_ff + 16'(data_byte);
      pleft = pairs_ff - 8'd1;
      sdone = samples_ff + 17'd1;
      mn = $signed(hmin_ff);
      mx = $signed(ns[63:32]);
      dim = (cls == tbsv_pkg::CLS_HEIGHT) ? tbsv_pkg::FINE_GRID : tbsv_pkg::COARSE_GRID;

      byte_total_in = byte_total_ff;
      phase_in = phase_ff;
      shift_in = shift_ff;
      palette_in = palette_ff;
      samples_in = samples_ff;
      pairs_in = pairs_ff;
      prior_in = prior_ff;
      weight_in = weight_ff;
      hmin_in = hmin_ff;
      fault_in = fault_ff;
      lower_we = 1'b0;
      lower_wa = 2'(k - 3'd1);

      if (fire && byte_present) begin
         if (byte_total_ff < tbsv_pkg::TOTAL_MAX) begin
            byte_total_in = byte_total_ff + 19'd1;
         end
         if (cls == tbsv_pkg::CLS_COVERAGE) begin
            if (first_error_ff == tbsv_pkg::ERR_OK) begin
               case (phase_ff)
                  tbsv_pkg::PH_HEADER: begin
                     shift_in = ns;
                     if (pos == 19'd4) begin
                        if (w != tbsv_pkg::COV_GRID || h != tbsv_pkg::COV_GRID ||
                            data_byte == 8'd0 || data_byte > cfg.max_palette_entries) begin
                           err = tbsv_pkg::ERR_COV_HEADER;
                        end else begin
                           palette_in = data_byte;
                           shift_in = 64'd0;
                           phase_in = tbsv_pkg::PH_PALETTE;
                        end
                     end
                  end
                  tbsv_pkg::PH_PALETTE: begin
                     if (({1'b0, pos} + 20'd1) == (20'd5 + {8'd0, palette_ff, 4'd0})) begin
                        phase_in = (samples_ff >= cfg.sample_count) ?
                                   tbsv_pkg::PH_TRAIL : tbsv_pkg::PH_COUNT;
                     end
                  end
                  tbsv_pkg::PH_COUNT: begin
                     if (data_byte == 8'd0 || data_byte > cfg.max_active_layers) begin
                        err = tbsv_pkg::ERR_COUNT;
                     end else begin
                        pairs_in = data_byte;
                        weight_in = 16'd0;
                        shift_in = 64'h100;
                        phase_in = tbsv_pkg::PH_INDEX;
                     end
                  end
                  tbsv_pkg::PH_INDEX: begin
                     shift_in = {55'd0, shift_ff[8], data_byte};
                     phase_in = tbsv_pkg::PH_WEIGHT;
                  end
                  tbsv_pkg::PH_WEIGHT: begin
                     if (shift_ff[7:0] >= palette_ff || data_byte == 8'd0 ||
                         (!first && shift_ff[7:0] <= prior_ff)) begin
                        err = tbsv_pkg::ERR_SAMPLE;
                     end else begin
                        prior_in = shift_ff[7:0];
                        weight_in = wsum;
                        shift_in = 64'd0;
                        pairs_in = pleft;
                        if (pleft != 8'd0) begin
                           phase_in = tbsv_pkg::PH_INDEX;
                        end else if (wsum != tbsv_pkg::WEIGHT_TARGET) begin
                           err = tbsv_pkg::ERR_WEIGHT_SUM;
                        end else begin
                           samples_in = sdone;
                           phase_in = (sdone >= cfg.sample_count) ?
                                      tbsv_pkg::PH_TRAIL : tbsv_pkg::PH_COUNT;
                        end
                     end
                  end
                  default: begin
                     err = tbsv_pkg::ERR_TRAILING;
                  end
               endcase
            end
         end else if (cls <= tbsv_pkg::CLS_QUERY && pos < tbsv_pkg::META_LEN) begin
            shift_in = ns;
            if (cls == tbsv_pkg::CLS_META) begin
               if (pos == 19'd3) begin
                  hmin_in = ns[63:32];
               end else if (pos == 19'd7) begin
                  if (mn < -32'sd32768 || mx > 32'sd32767 || mn > mx) begin
                     if (err == tbsv_pkg::ERR_OK) err = tbsv_pkg::ERR_META_HEADER;
                  end
               end else if (pos >= 19'd15 && pos <= 19'd63 && pos[2:0] == 3'd7) begin
                  if (!tbsv_pkg::is_finite(ns)) fault_in = 1'b1;
                  if (k >= 3'd1 && k <= 3'd3) begin
                     lower_we = 1'b1;
                  end else if (k >= 3'd4) begin
                     if (tbsv_pkg::is_finite(lower_ff[k[1:0]]) && tbsv_pkg::is_finite(ns) &&
                         tbsv_pkg::dbl_greater(lower_ff[k[1:0]], ns)) begin
                        fault_in = 1'b1;
                     end
                  end
               end else if (pos == 19'd64) begin
                  if (ns[63:56] != tbsv_pkg::DIR_ENTRIES && err == tbsv_pkg::ERR_OK) begin
                     err = tbsv_pkg::ERR_META_HEADER;
                  end
               end else if (pos >= 19'd65) begin
                  if (dj == 5'd0 && ns[63:56] != 8'(dk + 3'd1) && err == tbsv_pkg::ERR_OK) begin
                     err = tbsv_pkg::ERR_DIRECTORY;
                  end
                  if (dj == 5'd4 && ns[63:32] != tbsv_pkg::dir_ceiling(dk) &&
                      err == tbsv_pkg::ERR_OK) begin
                     err = tbsv_pkg::ERR_DIRECTORY;
                  end
               end
            end else if ((pos == 19'd1 || pos == 19'd3) && ns[63:48] != dim) begin
               if (err == tbsv_pkg::ERR_OK) err = tbsv_pkg::ERR_GRID;
            end
         end
      end
      first_error_in = err;
   end

   always_comb begin
      logic [2:0] cls;
      cls = cfg.product_class;
      if (byte_total_in == 19'd0 || byte_total_in > tbsv_pkg::size_bound(cls)) begin
         code = tbsv_pkg::ERR_SIZE;
      end else if (first_error_in != tbsv_pkg::ERR_OK) begin
         code = first_error_in;
      end else begin
         case (cls)
            tbsv_pkg::CLS_META: begin
               if (byte_total_in < 19'd65) code = tbsv_pkg::ERR_META_HEADER;
               else if (byte_total_in < tbsv_pkg::META_LEN) code = tbsv_pkg::ERR_DIRECTORY;
               else if (byte_total_in != tbsv_pkg::META_LEN || fault_in) begin
                  code = tbsv_pkg::ERR_META_VALUES;
               end else code = tbsv_pkg::ERR_OK;
            end
            tbsv_pkg::CLS_HEIGHT: begin
               code = (byte_total_in == tbsv_pkg::HEIGHT_LEN) ?
                      tbsv_pkg::ERR_OK : tbsv_pkg::ERR_GRID;
            end
            tbsv_pkg::CLS_COLLISION: begin
               code = (byte_total_in == tbsv_pkg::COLLISION_LEN) ?
                      tbsv_pkg::ERR_OK : tbsv_pkg::ERR_GRID;
            end
            tbsv_pkg::CLS_QUERY: begin
               code = (byte_total_in == tbsv_pkg::QUERY_LEN) ?
                      tbsv_pkg::ERR_OK : tbsv_pkg::ERR_GRID;
            end
            default: begin
               case (phase_in)
                  tbsv_pkg::PH_HEADER:  code = tbsv_pkg::ERR_COV_HEADER;
                  tbsv_pkg::PH_PALETTE: code = tbsv_pkg::ERR_PAL_TRUNC;
                  tbsv_pkg::PH_COUNT:   code = tbsv_pkg::ERR_COUNT;
                  tbsv_pkg::PH_INDEX:   code = tbsv_pkg::ERR_SMP_TRUNC;
                  tbsv_pkg::PH_WEIGHT:  code = tbsv_pkg::ERR_SMP_TRUNC;
                  default:              code = tbsv_pkg::ERR_OK;
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && last)) begin
         byte_total_ff <= 19'd0;
         phase_ff <= tbsv_pkg::PH_HEADER;
         shift_ff <= 64'd0;
         first_error_ff <= tbsv_pkg::ERR_OK;
         palette_ff <= 8'd0;
         samples_ff <= 17'd0;
         pairs_ff <= 8'd0;
         prior_ff <= 8'd0;
         weight_ff <= 16'd0;
         hmin_ff <= 32'd0;
         fault_ff <= 1'b0;
      end else begin
         byte_total_ff <= byte_total_in;
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         first_error_ff <= first_error_in;
         palette_ff <= palette_in;
         samples_ff <= samples_in;
         pairs_ff <= pairs_in;
         prior_ff <= prior_in;
         weight_ff <= weight_in;
         hmin_ff <= hmin_in;
         fault_ff <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lower_we) begin
         lower_ff[lower_wa] <= shift_in;
      end
   end

endmodule

>>> src/tile_body_stream_validator.sv
// Top level of the tile body validator: configuration registers and result register.
// Depends on tbsv_pkg, tbsv_req_if, tbsv_rsp_if and tbsv_core.
//
// The block takes at most one body byte per transaction and can accept a transaction
// in every clock cycle unless stalled; each accepted byte updates the registered parse
// state. The transaction marked last yields one verdict, held in the result register,
// in the cycle after acceptance. Input is stalled only while a verdict waits to be taken
// and the result side is not ready. Configuration must be written between bodies.
module tile_body_stream_validator (
   input  logic        clock,
   input  logic        reset,
   tbsv_req_if.sink    req_chan,
   tbsv_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_write_data
);

   tbsv_pkg::cfg_type cfg_ff;
   logic              rsp_valid_ff;
   logic [3:0]        rsp_code_ff;
   logic [3:0]        code;
   logic              fire;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.product_class <= tbsv_pkg::CLS_META;
         cfg_ff.max_palette_entries <= 8'd16;
         cfg_ff.max_active_layers <= 8'd4;
         cfg_ff.sample_count <= 17'd66049;
      end else if (csr_write_enable) begin
         case (csr_index)
            tbsv_pkg::CSR_PRODUCT_CLASS: cfg_ff.product_class <= csr_write_data[2:0];
            tbsv_pkg::CSR_MAX_PALETTE:   cfg_ff.max_palette_entries <= csr_write_data[7:0];
            tbsv_pkg::CSR_MAX_LAYERS:    cfg_ff.max_active_layers <= csr_write_data[7:0];
            tbsv_pkg::CSR_SAMPLE_COUNT:  cfg_ff.sample_count <= csr_write_data;
            default: ;
         endcase
      end
   end

   tbsv_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .fire         (fire),
      .data_byte    (req_chan.data_byte),
      .byte_present (req_chan.byte_present),
      .last         (req_chan.last),
      .code         (code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && req_chan.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && req_chan.last) begin
         rsp_code_ff <= code;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.error_code = rsp_code_ff;
   assign rsp_chan.valid_res = (rsp_code_ff == tbsv_pkg::ERR_OK);

   a_verdict_follows_last: assert property (@(posedge clock) disable iff (reset)
      fire && req_chan.last |=> rsp_valid_ff)
      else $error("No verdict after the final transaction of a body.");

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("Input accepted while a verdict is stalled.");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_code_ff <= tbsv_pkg::ERR_META_VALUES)
      else $error("Verdict carries an undefined error code.");

endmodule

>>> tb/sv/tile_body_stream_validator_test.sv
// Self-checking testbench for tile_body_stream_validator: random and directed tile bodies,
// verdicts predicted in-line and checked as each verdict is accepted.
// Depends on tbsv_pkg, tbsv_req_if, tbsv_rsp_if and the RTL of the block.
module tile_body_stream_validator_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last;
   } body_item_type;

   typedef struct packed {
      logic       valid_res;
      logic [3:0] error_code;
   } verdict_type;

   localparam int CYCLE_LIMIT = 6000000;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [16:0] csr_write_data;

   tbsv_req_if req ();
   tbsv_rsp_if rsp ();

   tile_body_stream_validator dut (
      .clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   body_item_type pending_items[$];
   verdict_type   expected_verdicts[$];
   logic [7:0]  body[$];
   int          send_gap_pct, recv_stall_pct;
   int          mismatches, verdicts_checked, bodies_sent, bytes_sent, cycles;
   logic        req_taken;

   // Shadow configuration and parse state of the block.
   logic [2:0]  cfg_class;
   logic [7:0]  cfg_max_palette, cfg_max_layers;
   logic [16:0] cfg_samples;
   logic [18:0] byte_total;
   logic [3:0]  phase, first_error;
   logic [63:0] shifter;
   logic [7:0]  palette_n, pairs_left, prior_idx;
   logic [16:0] samples_done;
   logic [15:0] weight_sum;
   logic [31:0] height_min;
   logic [63:0] lower_vals[3];
   logic        value_bad;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string what, input verdict_type got, input verdict_type want);
      $display("MISMATCH %s: got valid_res=%0d code=%0d, want valid_res=%0d code=%0d",
               what, got.valid_res, got.error_code, want.valid_res, want.error_code);
      mismatches++;
   endtask

   function automatic void clear_body();
      byte_total = '0; phase = tbsv_pkg::PH_HEADER; shifter = '0;
      first_error = tbsv_pkg::ERR_OK;
      palette_n = '0; samples_done = '0; pairs_left = '0; prior_idx = '0;
      weight_sum = '0; height_min = '0; value_bad = 1'b0;
   endfunction

   function automatic void note(input logic [3:0] code);
      if (first_error == tbsv_pkg::ERR_OK) first_error = code;
   endfunction

   function automatic logic finite64(input logic [63:0] v);
      return v[62:52] != 11'h7FF;
   endfunction

   function automatic logic above(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] ka, kb;
      if (a[62:0] == 0 && b[62:0] == 0) return 1'b0;
      ka = a[63] ? ~a : {1'b1, a[62:0]};
      kb = b[63] ? ~b : {1'b1, b[62:0]};
      return ka > kb;
   endfunction

   function automatic void meta_step(input int pos);
      logic signed [31:0] lo, hi;
      logic [31:0] ceil;
      int k, rel;
      hi = shifter[63:32];
      lo = height_min;
      if (pos == 3) begin
         height_min = shifter[63:32];
      end else if (pos == 7) begin
         if (lo < -32768 || hi > 32767 || lo > hi) note(tbsv_pkg::ERR_META_HEADER);
      end else if (pos >= 15 && pos <= 63 && ((pos - 15) % 8) == 0) begin
         k = (pos - 15) / 8;
         if (!finite64(shifter)) value_bad = 1'b1;
         if (k >= 1 && k <= 3) begin
            lower_vals[k - 1] = shifter;
         end else if (k >= 4) begin
            if (finite64(lower_vals[k - 4]) && finite64(shifter)
                && above(lower_vals[k - 4], shifter)) value_bad = 1'b1;
         end
      end else if (pos == 64) begin
         if (shifter[63:56] != 8'd5) note(tbsv_pkg::ERR_META_HEADER);
      end else if (pos >= 65 && pos <= 89) begin
         rel = pos - 65;
         case (rel / 5)
            0: ceil = 32'd16384;
            1: ceil = 32'd163840;
            2: ceil = 32'd327680;
            3: ceil = 32'd98304;
            default: ceil = 32'd163840;
         endcase
         if (rel % 5 == 0 && shifter[63:56] != rel / 5 + 1) note(tbsv_pkg::ERR_DIRECTORY);
         if (rel % 5 == 4 && shifter[63:32] != ceil) note(tbsv_pkg::ERR_DIRECTORY);
      end
   endfunction

   function automatic void samples_next();
      phase = (samples_done >= cfg_samples) ? tbsv_pkg::PH_TRAIL : tbsv_pkg::PH_COUNT;
   endfunction

   function automatic void coverage_step(input int pos, input logic [7:0] b);
      logic [7:0] idx;
      if (first_error != tbsv_pkg::ERR_OK) return;
      case (phase)
         tbsv_pkg::PH_HEADER: begin
            shifter = {b, shifter[63:8]};
            if (pos == 4) begin
               if (shifter[39:24] != 16'd257 || shifter[55:40] != 16'd257 || b == 0
                   || b > cfg_max_palette) begin
                  note(tbsv_pkg::ERR_COV_HEADER);
               end else begin
                  palette_n = b; shifter = '0; phase = tbsv_pkg::PH_PALETTE;
               end
            end
         end
         tbsv_pkg::PH_PALETTE: if (pos + 1 == 5 + int'(palette_n) * 16) samples_next();
         tbsv_pkg::PH_COUNT: begin
            if (b == 0 || b > cfg_max_layers) begin
               note(tbsv_pkg::ERR_COUNT);
            end else begin
               pairs_left = b; weight_sum = '0; shifter = 64'h100;
               phase = tbsv_pkg::PH_INDEX;
            end
         end
         tbsv_pkg::PH_INDEX: begin
            shifter = (shifter & 64'h100) | b;
            phase = tbsv_pkg::PH_WEIGHT;
         end
         tbsv_pkg::PH_WEIGHT: begin
            idx = shifter[7:0];
            if (idx >= palette_n || b == 0 || (!shifter[8] && idx <= prior_idx)) begin
               note(tbsv_pkg::ERR_SAMPLE);
            end else begin
               prior_idx = idx; weight_sum += b; shifter = '0; pairs_left--;
               if (pairs_left != 0) begin
                  phase = tbsv_pkg::PH_INDEX;
               end else if (weight_sum != 16'd255) begin
                  note(tbsv_pkg::ERR_WEIGHT_SUM);
               end else begin
                  samples_done++;
                  samples_next();
               end
            end
         end
         default: note(tbsv_pkg::ERR_TRAILING);
      endcase
   endfunction

   function automatic logic [3:0] body_verdict();
      logic [18:0] bound;
      case (cfg_class)
         tbsv_pkg::CLS_META:      bound = 19'd16276;
         tbsv_pkg::CLS_HEIGHT:    bound = 19'd163732;
         tbsv_pkg::CLS_COVERAGE:  bound = 19'd327572;
         tbsv_pkg::CLS_COLLISION: bound = 19'd98196;
         tbsv_pkg::CLS_QUERY:     bound = 19'd163732;
         default:                 bound = 19'd0;
      endcase
      if (byte_total == 0 || byte_total > bound) return tbsv_pkg::ERR_SIZE;
      if (first_error != tbsv_pkg::ERR_OK) return first_error;
      case (cfg_class)
         tbsv_pkg::CLS_META: begin
            if (byte_total < 65) return tbsv_pkg::ERR_META_HEADER;
            if (byte_total < 90) return tbsv_pkg::ERR_DIRECTORY;
            if (byte_total != 90 || value_bad) return tbsv_pkg::ERR_META_VALUES;
            return tbsv_pkg::ERR_OK;
         end
         tbsv_pkg::CLS_HEIGHT:
            return byte_total == 19'd132102 ? tbsv_pkg::ERR_OK : tbsv_pkg::ERR_GRID;
         tbsv_pkg::CLS_COLLISION:
            return byte_total == 19'd33286 ? tbsv_pkg::ERR_OK : tbsv_pkg::ERR_GRID;
         tbsv_pkg::CLS_QUERY:
            return byte_total == 19'd116491 ? tbsv_pkg::ERR_OK : tbsv_pkg::ERR_GRID;
         default: begin
            case (phase)
               tbsv_pkg::PH_HEADER:  return tbsv_pkg::ERR_COV_HEADER;
               tbsv_pkg::PH_PALETTE: return tbsv_pkg::ERR_PAL_TRUNC;
               tbsv_pkg::PH_COUNT:   return tbsv_pkg::ERR_COUNT;
               tbsv_pkg::PH_INDEX, tbsv_pkg::PH_WEIGHT:
                                     return tbsv_pkg::ERR_SMP_TRUNC;
               default:              return tbsv_pkg::ERR_OK;
            endcase
         end
      endcase
   endfunction

   function automatic void predict_transaction(input body_item_type it);
      int pos;
      logic [3:0] code;
      if (it.byte_present) begin
         pos = byte_total;
         if (byte_total < tbsv_pkg::TOTAL_MAX) byte_total++;
         if (cfg_class == tbsv_pkg::CLS_COVERAGE) begin
            coverage_step(pos, it.data_byte);
         end else if (cfg_class <= tbsv_pkg::CLS_QUERY && pos < 90) begin
            shifter = {it.data_byte, shifter[63:8]};
            if (cfg_class == tbsv_pkg::CLS_META) begin
               meta_step(pos);
            end else if ((pos == 1 || pos == 3) && shifter[63:48]
                         != (cfg_class == tbsv_pkg::CLS_HEIGHT ? 16'd257 : 16'd129)) begin
               note(tbsv_pkg::ERR_GRID);
            end
         end
      end
      if (it.last) begin
         code = body_verdict();
         expected_verdicts.push_back({code == tbsv_pkg::ERR_OK, code});
         clear_body();
      end
   endfunction

   // Drives rsp.ready; presents the next pending transaction once the current is taken.
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= $urandom_range(99) >= recv_stall_pct;
         if (!req.valid || req_taken) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
               {req.data_byte, req.byte_present, req.last} <= pending_items.pop_front();
               req.valid <= 1'b1;
            end else begin
               req.valid <= 1'b0;
            end
         end
         req_taken = 1'b0;
      end
   end

   // Monitor: predicts on accepted input and checks each accepted verdict.
   always @(posedge clock) begin
      verdict_type got;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
      if (!reset) begin
         if (req.valid && req.ready) begin
            req_taken = 1'b1;
            predict_transaction({req.data_byte, req.byte_present, req.last});
         end
         if (rsp.valid && rsp.ready) begin
            got = {rsp.valid_res, rsp.error_code};
            verdicts_checked++;
            if (expected_verdicts.size() == 0) report("unexpected verdict", got, got);
            else if (got != expected_verdicts[0]) report("verdict", got, expected_verdicts[0]);
            if (expected_verdicts.size() > 0) void'(expected_verdicts.pop_front());
         end
      end
   end

   task automatic settle();
      while (pending_items.size() > 0 || req.valid || expected_verdicts.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [16:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         tbsv_pkg::CSR_PRODUCT_CLASS: cfg_class = value[2:0];
         tbsv_pkg::CSR_MAX_PALETTE:   cfg_max_palette = value[7:0];
         tbsv_pkg::CSR_MAX_LAYERS:    cfg_max_layers = value[7:0];
         default:                     cfg_samples = value;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(input logic [2:0] cls, input logic [7:0] pal,
                            input logic [7:0] lay, input logic [16:0] smp);
      write_csr(tbsv_pkg::CSR_PRODUCT_CLASS, 17'(cls));
      write_csr(tbsv_pkg::CSR_MAX_PALETTE, 17'(pal));
      write_csr(tbsv_pkg::CSR_MAX_LAYERS, 17'(lay));
      write_csr(tbsv_pkg::CSR_SAMPLE_COUNT, smp);
   endtask

   // Sends the bytes in body as one tile body, with absent bytes scattered in.
   task automatic send_body();
      body_item_type it;
      logic ended;
      ended = 1'b0;
      bodies_sent++;
      while (body.size() > 0) begin
         if ($urandom_range(99) < 3) pending_items.push_back({8'($urandom), 1'b0, 1'b0});
         it = {body.pop_front(), 1'b1, 1'b0};
         if (body.size() == 0 && $urandom_range(9) != 0) begin
            it.last = 1'b1;
            ended = 1'b1;
         end
         pending_items.push_back(it);
         bytes_sent++;
      end
      if (!ended) pending_items.push_back({8'($urandom), 1'b0, 1'b1});
   endtask

   task automatic put_le(input logic [63:0] v, input int n);
      for (int i = 0; i < n; i++) body.push_back(v[8*i +: 8]);
   endtask

   task automatic spoil(input int pct);
      int p;
      if ($urandom_range(99) >= pct || body.size() == 0) return;
      case ($urandom_range(2))
         0: begin
            p = $urandom_range(body.size() - 1);
            body[p] = body[p] ^ (8'h1 << $urandom_range(7));
         end
         1: repeat ($urandom_range(1, body.size())) void'(body.pop_back());
         default: repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
      endcase
   endtask

   function automatic logic [63:0] rand_double(input logic allow_special);
      case ($urandom_range(11))
         0: return 64'h0;
         1: return 64'h8000_0000_0000_0000;
         2: return allow_special ? {1'($urandom), 11'h7FF, 52'h0} : 64'h3FF0_0000_0000_0000;
         3: return allow_special ? {1'($urandom), 11'h7FF, 20'($urandom) | 20'h1, 32'($urandom)}
                                 : 64'hBFF0_0000_0000_0000;
         default: return {1'($urandom), 11'($urandom_range(11'h7FE)), 20'($urandom),
                          32'($urandom)};
      endcase
   endfunction

   task automatic make_meta(input int spoil_pct);
      logic signed [31:0] lo, hi;
      logic [63:0] a, b, t;
      logic [63:0] lows[3], highs[3];
      logic [31:0] ceilings[5];
      ceilings = '{32'd16384, 32'd163840, 32'd327680, 32'd98304, 32'd163840};
      lo = $urandom_range(65535) - 32768;
      hi = lo + $urandom_range(32767 - lo);
      if ($urandom_range(9) == 0) hi = $urandom;
      put_le(lo, 4);
      put_le(hi, 4);
      put_le(rand_double($urandom_range(9) == 0), 8);
      for (int i = 0; i < 3; i++) begin
         a = rand_double($urandom_range(9) == 0);
         b = ($urandom_range(5) == 0) ? a : rand_double($urandom_range(9) == 0);
         if (above(a, b) && $urandom_range(4) != 0) begin
            t = a; a = b; b = t;
         end
         lows[i] = a;
         highs[i] = b;
      end
      for (int i = 0; i < 3; i++) put_le(lows[i], 8);
      for (int i = 0; i < 3; i++) put_le(highs[i], 8);
      body.push_back(8'd5);
      for (int k = 0; k < 5; k++) begin
         body.push_back(8'(k + 1));
         put_le(ceilings[k], 4);
      end
      spoil(spoil_pct);
   endtask

   task automatic make_grid(input logic [15:0] dim, input int len);
      put_le(dim, 2);
      put_le(dim, 2);
      for (int i = 4; i < len; i++) body.push_back(8'($urandom));
   endtask

   task automatic make_coverage(input int spoil_pct);
      int n, c, nsamp, left, cap;
      int picks[$];
      n = $urandom_range(1, cfg_max_palette < 4 ? cfg_max_palette : 4);
      put_le(64'd257, 2);
      put_le(64'd257, 2);
      body.push_back(8'(n));
      repeat (n * 16) body.push_back(8'($urandom));
      nsamp = cfg_samples <= 6 ? cfg_samples : $urandom_range(1, 3);
      repeat (nsamp) begin
         cap = n < cfg_max_layers ? n : cfg_max_layers;
         if (cap > 6) cap = 6;
         c = $urandom_range(1, cap);
         picks.delete();
         for (int i = 0; i < n && picks.size() < c; i++)
            if ($urandom_range(n - i - 1) < c - picks.size()) picks.push_back(i);
         body.push_back(8'(c));
         left = 255;
         for (int i = 0; i < c; i++) begin
            body.push_back(8'(picks[i]));
            if (i == c - 1) begin
               body.push_back(8'(left));
            end else begin
               cap = $urandom_range(1, left - (c - 1 - i));
               if (cap > 200) cap = 200;
               body.push_back(8'(cap));
               left -= cap;
            end
         end
      end
      spoil(spoil_pct);
   endtask

   task automatic make_for_class(input int spoil_pct);
      if ($urandom_range(19) == 0) begin
         repeat ($urandom_range(0, 40)) body.push_back(8'($urandom));
      end else begin
         case (cfg_class)
            tbsv_pkg::CLS_META:      make_meta(spoil_pct);
            tbsv_pkg::CLS_COVERAGE:  make_coverage(spoil_pct);
            tbsv_pkg::CLS_HEIGHT:    make_grid($urandom_range(3) ? 16'd257 : 16'($urandom),
                                               $urandom_range(0, 30));
            tbsv_pkg::CLS_COLLISION, tbsv_pkg::CLS_QUERY:
                                     make_grid($urandom_range(3) ? 16'd129 : 16'($urandom),
                                               $urandom_range(0, 30));
            default:       repeat ($urandom_range(1, 8)) body.push_back(8'($urandom));
         endcase
      end
      send_body();
   endtask

   function automatic logic [7:0] pick_limit();
      case ($urandom_range(3))
         0: return 8'd1;
         1: return 8'd255;
         default: return 8'($urandom_range(1, 8));
      endcase
   endfunction

   initial begin
      int target;
      logic [2:0] cls;
      logic [16:0] smp;
      reset = 1'b1;
      req.valid = 1'b0;
      req.data_byte = '0;
      req.byte_present = 1'b0;
      req.last = 1'b0;
      rsp.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      send_gap_pct = 8;
      recv_stall_pct = 87;
      cfg_class = tbsv_pkg::CLS_META;
      cfg_max_palette = 8'd16;
      cfg_max_layers = 8'd4;
      cfg_samples = 17'd66049;
      lower_vals = '{default: '0};
      clear_body();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: an empty body and the defaults, then more classes and the extremes.
      send_body();
      make_meta(0);
      send_body();
      settle();
      configure(3'd5, 8'd1, 8'd1, 17'd0);
      body.push_back(8'hA5);
      send_body();
      settle();
      configure(tbsv_pkg::CLS_COVERAGE, 8'd1, 8'd1, 17'd0);
      make_coverage(0);
      send_body();
      make_coverage(0);
      body.push_back(8'h00);
      send_body();
      settle();
      configure(tbsv_pkg::CLS_COVERAGE, 8'd255, 8'd255, 17'd2);
      make_coverage(0);
      void'(body.pop_back());
      send_body();
      make_coverage(0);
      send_body();
      settle();
      configure(tbsv_pkg::CLS_COLLISION, 8'd16, 8'd4, 17'd66049);
      make_grid(16'd129, 9);
      send_body();
      make_grid(16'hFFFF, 4);
      send_body();
      settle();

      // Random part in three idling regimes.
      for (int r = 0; r < 3; r++) begin
         send_gap_pct = r == 0 ? 8 : (r == 1 ? 87 : 0);
         recv_stall_pct = r == 0 ? 87 : (r == 1 ? 8 : 0);
         target = bytes_sent + 250;
         while (bytes_sent < target) begin
            cls = $urandom_range(19) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
            smp = $urandom_range(9) == 0 ? 17'd66049 : 17'($urandom_range(0, 4));
            configure(cls, pick_limit(), pick_limit(), smp);
            repeat ($urandom_range(3, 6)) if (bytes_sent < target) make_for_class(35);
            settle();
         end
      end

      $display("covered %0d bodies, %0d body bytes, %0d verdicts checked, %0d mismatches",
               bodies_sent, bytes_sent, verdicts_checked, mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
